FILE: design/geo_tile_pkg.sv
// Shared types, constants and helper functions for the geo tile index unit.
// Used by geo_tile_prep, geo_tile_qmod and geo_tile_index_from_lonlat_unit.
// Depends on nothing else.
package geo_tile_pkg;

    // Width of the non-negative magnitudes that reach the quotient units.
    localparam int MAG_W = 34;
    localparam int ZOOM_W = 6;
    localparam int IDX_W = 16;

    // Degrees in a full turn and the odd factor that 360 and 180 share.
    localparam int LON_DEG = 360;
    localparam int MOD_BASE = 45;

    // floor(x / 360) = (x * LON_RECIP) >> LON_RECIP_SHIFT for x below 2^30.
    localparam logic [31:0] LON_RECIP = 32'd3054198967;
    localparam int LON_RECIP_SHIFT = 40;

    // floor(x / 45) = (x * RECIP45) >> RECIP45_SHIFT for any 14-bit x.
    localparam logic [13:0] RECIP45 = 14'd11651;
    localparam int RECIP45_SHIFT = 19;

    // Multiplicative inverse of 45 modulo 2^16.
    localparam logic [15:0] INV45 = 16'd20389;

    // Powers of two repeat modulo 45 with period 12, so 12-bit chunks add up.
    localparam int CHUNK_W = 12;

    typedef struct packed {
        logic [MAG_W-1:0]  lon_off;
        logic [MAG_W-1:0]  colat;
        logic [ZOOM_W-1:0] zoom;
    } prep_word_t;

    // Remainder of a 6-bit value by 12, using a reciprocal multiply.
    function automatic logic [3:0] mod12(input logic [5:0] val);
        logic [11:0] prod;
        logic [2:0]  quo;
        logic [5:0]  rem;
        prod = 12'(val) * 12'd43;
        quo  = prod[11:9];
        rem  = val - 6'(quo) * 6'd12;
        return rem[3:0];
    endfunction

endpackage

FILE: design/geo_tile_prep.sv
// Front end of the geo tile pipeline: zoom clamp, longitude wrap, colatitude.
// Four register stages. Depends on geo_tile_pkg.
module geo_tile_prep
    import geo_tile_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int MAX_ZOOM  = 62
)
(
    input  logic              clk,
    input  logic              adv,
    input  logic signed [31:0] lon_fixed,
    input  logic signed [31:0] lat_fixed,
    input  logic [15:0]       zoom_req,
    output prep_word_t        prep_word
);

    localparam int HW = 32 - FRAC_BITS;
    localparam int RW = FRAC_BITS + 9;
    localparam logic [MAG_W-1:0] QUARTER    = MAG_W'(90) << FRAC_BITS;
    localparam logic [MAG_W-1:0] HALF       = MAG_W'(180) << FRAC_BITS;
    localparam logic [MAG_W-1:0] THREE_HALF = MAG_W'(540) << FRAC_BITS;

    // Stage 1 registers.
    logic [ZOOM_W-1:0] z1_reg, z1_next;
    logic              neg1_reg, neg1_next;
    logic [31:0]       mag1_reg, mag1_next;
    logic [MAG_W-1:0]  t1_reg, t1_next;

    // Stage 2 registers.
    logic [ZOOM_W-1:0]    z2_reg;
    logic                 neg2_reg;
    logic [HW-1:0]        h2_reg, h2_next;
    logic [FRAC_BITS-1:0] f2_reg, f2_next;
    logic [HW-1:0]        q2_reg, q2_next;
    logic [MAG_W-1:0]     tm2_reg, tm2_next;
    logic [HW+39:0]       prod2;

    // Stage 3 registers.
    logic [ZOOM_W-1:0] z3_reg;
    logic              neg3_reg;
    logic [RW-1:0]     r3_reg, r3_next;
    logic [MAG_W-1:0]  tm3_reg;
    logic [HW+8:0]     b3_full;

    // Stage 4 register.
    prep_word_t        prep4_reg, prep4_next;
    logic [MAG_W-1:0]  r4_ext;

    always_comb
    begin
        z1_next   = (zoom_req > 16'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_req[ZOOM_W-1:0];
        neg1_next = lon_fixed[31];
        mag1_next = lon_fixed[31] ? (~lon_fixed + 32'd1) : lon_fixed;
        t1_next   = QUARTER - {{(MAG_W-32){lat_fixed[31]}}, lat_fixed};
    end

    always_comb
    begin
        h2_next  = mag1_reg[31:FRAC_BITS];
        f2_next  = mag1_reg[FRAC_BITS-1:0];
        prod2    = (HW+40)'(h2_next) * (HW+40)'(LON_RECIP);
        q2_next  = prod2[LON_RECIP_SHIFT +: HW];
        tm2_next = t1_reg[MAG_W-1] ? (~t1_reg + MAG_W'(1)) : t1_reg;
    end

    always_comb
    begin
        b3_full = (HW+9)'(h2_reg) - (HW+9)'(q2_reg) * (HW+9)'(LON_DEG);
        r3_next = {b3_full[8:0], f2_reg};
    end

    // A negative remainder lands below zero after the half-turn shift only when
    // it exceeds half a turn; then one more full turn is added.
    always_comb
    begin
        r4_ext = MAG_W'(r3_reg);
        if (!neg3_reg)
        begin
            prep4_next.lon_off = r4_ext + HALF;
        end
        else if (r4_ext <= HALF)
        begin
            prep4_next.lon_off = HALF - r4_ext;
        end
        else
        begin
            prep4_next.lon_off = THREE_HALF - r4_ext;
        end
        prep4_next.colat = tm3_reg;
        prep4_next.zoom  = z3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z1_reg    <= z1_next;
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            t1_reg    <= t1_next;
            z2_reg    <= z1_reg;
            neg2_reg  <= neg1_reg;
            h2_reg    <= h2_next;
            f2_reg    <= f2_next;
            q2_reg    <= q2_next;
            tm2_reg   <= tm2_next;
            z3_reg    <= z2_reg;
            neg3_reg  <= neg2_reg;
            r3_reg    <= r3_next;
            tm3_reg   <= tm2_reg;
            prep4_reg <= prep4_next;
        end
    end

    assign prep_word = prep4_reg;

endmodule

FILE: design/geo_tile_qmod.sv
// Pipelined scaled quotient: floor(mag * 2^scale / (45 * 2^SHIFT)) mod 2^16.
// Five register stages. Depends on geo_tile_pkg.
module geo_tile_qmod
    import geo_tile_pkg::*;
#(
    parameter int SHIFT = 23
)
(
    input  logic             clk,
    input  logic             adv,
    input  logic [MAG_W-1:0] mag,
    input  logic [6:0]       scale,
    output logic [15:0]      quot
);

    localparam logic [6:0] SHIFT7 = 7'(SHIFT);

    // Stage 0: shift amounts.
    logic [MAG_W-1:0] mag0_reg;
    logic [4:0]       d0_reg, d0_next;
    logic [5:0]       j0_reg, j0_next;
    logic [3:0]       k0_reg, k0_next;
    logic [6:0]       j0_full;

    // Stage 1: low quotient bits of the shifted value and its chunk sum.
    logic [MAG_W-1:0] v1;
    logic [47:0]      w1;
    logic [15:0]      p1_reg, p1_next;
    logic [13:0]      s1_reg, s1_next;

    // Stage 2: chunk sum divided by 45.
    logic [27:0]      prod2;
    logic [8:0]       q2_reg, q2_next;
    logic [13:0]      s2_reg;
    logic [15:0]      p2_reg;

    // Stage 3: remainder modulo 45.
    logic [13:0]      rem3;
    logic [5:0]       m3_reg, m3_next;
    logic [15:0]      p3_reg;

    // Stage 4: exact division by 45 modulo 2^16.
    logic [15:0]      diff4;
    logic [15:0]      quot_reg, quot_next;

    always_comb
    begin
        d0_next = (SHIFT7 > scale) ? 5'(SHIFT7 - scale) : 5'd0;
        j0_full = (scale > SHIFT7) ? (scale - SHIFT7) : 7'd0;
        j0_next = j0_full[5:0];
        k0_next = mod12(j0_next);
    end

    // 2^12 is 1 modulo 45, so the sum of 12-bit chunks keeps the residue.
    always_comb
    begin
        v1      = mag0_reg >> d0_reg;
        w1      = 48'(v1) << k0_reg;
        p1_next = v1[15:0] << j0_reg;
        s1_next = 14'(w1[CHUNK_W-1:0]) + 14'(w1[2*CHUNK_W-1:CHUNK_W])
                + 14'(w1[3*CHUNK_W-1:2*CHUNK_W]) + 14'(w1[4*CHUNK_W-1:3*CHUNK_W]);
    end

    always_comb
    begin
        prod2   = 28'(s1_reg) * 28'(RECIP45);
        q2_next = prod2[RECIP45_SHIFT +: 9];
    end

    always_comb
    begin
        rem3    = s2_reg - 14'(q2_reg) * 14'(MOD_BASE);
        m3_next = rem3[5:0];
    end

    // Subtracting the residue leaves a multiple of 45, which the inverse divides.
    always_comb
    begin
        diff4     = p3_reg - 16'(m3_reg);
        quot_next = diff4 * INV45;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag0_reg <= mag;
            d0_reg   <= d0_next;
            j0_reg   <= j0_next;
            k0_reg   <= k0_next;
            p1_reg   <= p1_next;
            s1_reg   <= s1_next;
            q2_reg   <= q2_next;
            s2_reg   <= s1_reg;
            p2_reg   <= p1_reg;
            m3_reg   <= m3_next;
            p3_reg   <= p2_reg;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

FILE: design/geo_tile_index_from_lonlat_unit.sv
// Top level of the geo tile index unit: equirectangular tile from lon/lat/zoom.
// Instantiates geo_tile_prep and three geo_tile_qmod units; uses geo_tile_pkg.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------------
//   point   | pt_valid / pt_stall     | lon_fixed, lat_fixed, zoom_req
//   tile    | tile_valid / tile_stall | tile_col, tile_row, tile_zoom, tile_packed
//
// Every word passes through the pipeline: four front-end stages, five
// stages in the quotient units and the output register. One word enters per
// cycle while the output is not stalled.
// Reset clears only the valid bits that travel with the words.
// A stalled output word freezes every stage at once, and pt_stall rises with
// it, so no word is dropped or repeated.
module geo_tile_index_from_lonlat_unit
    import geo_tile_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int MAX_ZOOM  = 62
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pt_valid,
    output logic               pt_stall,
    input  logic signed [31:0] lon_fixed,
    input  logic signed [31:0] lat_fixed,
    input  logic [15:0]        zoom_req,
    output logic               tile_valid,
    input  logic               tile_stall,
    output logic [15:0]        tile_col,
    output logic [15:0]        tile_row,
    output logic [5:0]         tile_zoom,
    output logic [47:0]        tile_packed
);

    localparam int QMOD_DEPTH = 5;
    localparam int PIPE_DEPTH = 4 + QMOD_DEPTH + 1;

    logic                  adv;
    logic                  accept;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    prep_word_t            prep_word;
    logic [6:0]            col_scale;
    logic [6:0]            row_scale;
    logic [15:0]           col_quot;
    logic [15:0]           row_quot;
    logic [15:0]           fold_quot;

    logic [ZOOM_W-1:0]     zd_reg [QMOD_DEPTH];

    logic [ZOOM_W-1:0]     zq;
    logic [15:0]           idx_mask;
    logic [15:0]           col_reg, col_next;
    logic [15:0]           row_reg, row_next;
    logic [ZOOM_W-1:0]     zoom_reg;

    // The whole pipeline moves together unless the output word is held.
    assign adv      = !(tile_valid && tile_stall);
    assign pt_stall = !adv;
    assign accept   = pt_valid && adv;

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    geo_tile_prep #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ZOOM  (MAX_ZOOM)
    ) u_prep (
        .clk       (clk),
        .adv       (adv),
        .lon_fixed (lon_fixed),
        .lat_fixed (lat_fixed),
        .zoom_req  (zoom_req),
        .prep_word (prep_word)
    );

    // The column grid splits 360 degrees (45 * 8) into 2^(z+1) columns; the
    // row grid splits 180 degrees (45 * 4) into 2^z rows.
    assign col_scale = 7'(prep_word.zoom) + 7'd1;
    assign row_scale = 7'(prep_word.zoom);

    geo_tile_qmod #(
        .SHIFT (FRAC_BITS + 3)
    ) u_col (
        .clk   (clk),
        .adv   (adv),
        .mag   (prep_word.lon_off),
        .scale (col_scale),
        .quot  (col_quot)
    );

    geo_tile_qmod #(
        .SHIFT (FRAC_BITS + 2)
    ) u_row (
        .clk   (clk),
        .adv   (adv),
        .mag   (prep_word.colat),
        .scale (row_scale),
        .quot  (row_quot)
    );

    // Bit z of the raw row equals the parity of the number of whole half
    // turns in the colatitude, which tells whether the point is past the
    // south pole and the row has to fold back.
    geo_tile_qmod #(
        .SHIFT (FRAC_BITS + 2)
    ) u_fold (
        .clk   (clk),
        .adv   (adv),
        .mag   (prep_word.colat),
        .scale (7'd0),
        .quot  (fold_quot)
    );

    // The zoom level rides alongside the quotient units.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zd_reg[0] <= prep_word.zoom;
            for (int i = 1; i < QMOD_DEPTH; i++)
            begin
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    // Column and row both wrap at 2^(z+1) before the 16-bit cut; a folded
    // row is the ones' complement of the raw row within that width.
    always_comb
    begin
        zq       = zd_reg[QMOD_DEPTH-1];
        idx_mask = (zq >= 6'd15) ? 16'hFFFF
                                 : 16'((17'd1 << (zq + 6'd1)) - 17'd1);
        col_next = col_quot & idx_mask;
        row_next = (fold_quot[0] ? ~row_quot : row_quot) & idx_mask;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            zoom_reg <= zq;
        end
    end

    assign tile_valid  = vld_reg[PIPE_DEPTH-1];
    assign tile_col    = col_reg;
    assign tile_row    = row_reg;
    assign tile_zoom   = zoom_reg;
    assign tile_packed = {col_reg, row_reg, 10'd0, zoom_reg};

`ifndef SYNTHESIS
    a_zoom_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid |-> (tile_zoom <= 6'(MAX_ZOOM)))
        else $error("tile zoom above the clamp limit");

    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_valid && (tile_zoom < 6'd15)) |-> ((tile_col >> (tile_zoom + 6'd1)) == 16'd0))
        else $error("tile column outside the column count");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_valid && (tile_zoom < 6'd16)) |-> ((tile_row >> tile_zoom) == 16'd0))
        else $error("tile row outside the row count after the pole fold");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && !pt_stall) |=> vld_reg[0])
        else $error("accepted point word did not enter the pipeline");
`endif

endmodule
